@@ rtl/slab_bitmap_handle_allocator_macros.svh @@
// Assertion macros used by the checker file of the slab handle allocator.
`ifndef SLAB_BITMAP_HANDLE_ALLOCATOR_MACROS_SVH
`define SLAB_BITMAP_HANDLE_ALLOCATOR_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the reset is low.
`define SBHA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define SBHA_ASSERT(lbl, prop, msg) \
    `SBHA_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

@@ rtl/sbha_pkg.sv @@
package sbha_pkg;

    // Pool geometry.
    localparam int SLABS    = 8;
    localparam int HANDLES  = 64;
    localparam int WORD_W   = 64;
    localparam int SLAB_W   = $clog2(SLABS);
    localparam int SLOT_W   = 6;
    localparam int HANDLE_W = 9;
    localparam int BYTES    = WORD_W / 8;
    localparam int BYTE_W   = $clog2(BYTES);

    // Configuration port.
    localparam int SLOTS_W    = 7;
    localparam int LIMIT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_SLAB = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAB_LIMIT     = 2'd1;

    // Commands and result codes.
    localparam logic       CMD_ALLOC    = 1'b0;
    localparam logic       CMD_FREE     = 1'b1;
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_BADFREE = 2'd2;

    typedef struct packed {
        logic                command;
        logic [HANDLE_W-1:0] handle_to_free;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] handle_given;
        logic                slab_released;
        logic                slab_opened;
    } t_out_item;

    // Write to one slab cell.
    typedef struct packed {
        logic              en;
        logic [SLAB_W-1:0] slab;
        logic [WORD_W-1:0] word;
        logic              live;
    } t_slab_wr;

    // Search link along the slab cells for the lowest unused slab.
    typedef struct packed {
        logic              found;
        logic [SLAB_W-1:0] idx;
    } t_open_link;

    // Operation applied to the stack cells.
    typedef struct packed {
        logic push;
        logic pop;
        logic remove;
    } t_stk_op;

    // Contents of one stack cell as seen by its neighbour.
    typedef struct packed {
        logic              valid;
        logic [SLAB_W-1:0] entry;
    } t_stk_link;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_UPDATE
    } t_state;

    typedef enum logic [1:0] {
        M_FREE,
        M_TOP,
        M_OPEN
    } t_mode;

endpackage

@@ rtl/sbha_slab_cell.sv @@
module sbha_slab_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sbha_pkg::SLAB_W-1:0]      i_index,
    input  logic [sbha_pkg::LIMIT_W-1:0]     i_limit,
    input  sbha_pkg::t_slab_wr               i_wr,
    input  sbha_pkg::t_open_link             i_link,
    output sbha_pkg::t_open_link             o_link,
    output logic [sbha_pkg::WORD_W-1:0]      o_word,
    output logic                             o_live
);

    logic [sbha_pkg::WORD_W-1:0] r_word, n_word;
    logic                        r_live, n_live;
    logic                        wr_hit;
    logic                        below_lim;

    // This cell takes a write addressed to its own slab number.
    assign wr_hit = i_wr.en && (i_wr.slab == i_index);

    always_comb begin
        n_word = r_word;
        n_live = r_live;
        if (wr_hit) begin
            n_word = i_wr.word;
            n_live = i_wr.live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_live <= 1'b0;
        end else begin
            r_word <= n_word;
            r_live <= n_live;
        end
    end

    // The lowest unused slab under the limit wins; a find further down the chain passes through.
    assign below_lim = {{(sbha_pkg::LIMIT_W - sbha_pkg::SLAB_W){1'b0}}, i_index} < i_limit;
    assign o_link.found = i_link.found || (!r_live && below_lim);
    assign o_link.idx   = i_link.found ? i_link.idx : i_index;

    assign o_word = r_word;
    assign o_live = r_live;

endmodule

@@ rtl/sbha_stack_cell.sv @@
module sbha_stack_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbha_pkg::t_stk_op           i_op,
    input  logic [sbha_pkg::SLAB_W-1:0] i_slab,
    input  sbha_pkg::t_stk_link         i_above,
    input  logic [sbha_pkg::SLAB_W-1:0] i_top_in,
    input  logic                        i_below_valid,
    input  logic                        i_hit_in,
    output sbha_pkg::t_stk_link         o_cell,
    output logic [sbha_pkg::SLAB_W-1:0] o_top_out,
    output logic                        o_hit_out
);

    logic                        r_valid, n_valid;
    logic [sbha_pkg::SLAB_W-1:0] r_entry, n_entry;
    logic                        hit_here;

    // Match on the slab under work; the match ripples upwards along the chain.
    assign hit_here  = r_valid && (r_entry == i_slab);
    assign o_hit_out = i_hit_in || hit_here;

    // The top entry ripples downwards: the highest valid cell supplies it.
    assign o_top_out = i_above.valid ? i_top_in : r_entry;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_op.remove && (i_hit_in || hit_here)) begin
            // Cells from the match upwards take their upper neighbour's contents.
            n_valid = i_above.valid;
            n_entry = i_above.entry;
        end else if (i_op.pop && r_valid && !i_above.valid) begin
            n_valid = 1'b0;
        end else if (i_op.push && !r_valid && i_below_valid) begin
            n_valid = 1'b1;
            n_entry = i_slab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.entry = r_entry;

endmodule

@@ rtl/slab_bitmap_handle_allocator.sv @@
// Slab handle allocator.
// Input channel (i_in_valid / o_in_ready, i_in_data): one item per command, either an
// allocation or the free of a handle given as slab * 64 + slot.
// Output channel (o_out_valid / i_out_ready, o_out_data): exactly one result item per
// command, carrying the status, the new handle, and the slab opened and released flags.
// Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data): index 0 sets
// the slots in use per slab, index 1 the slab limit. It is always ready. The user must see
// that it is written only while the block is idle; the block itself does not enforce this.
// Each item passes in turn through acceptance with slab selection, a read of the slab's
// bitmap from its cell, a byte-wise scan of that bitmap, and the update of the slab cells
// and the stack cells. A new item is accepted only after the previous one has finished
// its update. The scan of the 64-bit bitmap and the rippling search along the cell chains
// set this division into steps.
// A stalled output register holds its result; the next item is still accepted and worked
// on, and its update waits until the output register is free.
// After reset all slabs are released, the stack is empty and the registers hold 64 slots
// per slab and a limit of 8 slabs.
module slab_bitmap_handle_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  sbha_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output sbha_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sbha_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sbha_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SLABS  = sbha_pkg::SLABS;
    localparam int SLAB_W = sbha_pkg::SLAB_W;
    localparam int WORD_W = sbha_pkg::WORD_W;
    localparam int SLOT_W = sbha_pkg::SLOT_W;
    localparam int BYTES  = sbha_pkg::BYTES;
    localparam int BYTE_W = sbha_pkg::BYTE_W;

    // Configuration registers.
    logic [sbha_pkg::SLOTS_W-1:0] r_slots;
    logic [sbha_pkg::LIMIT_W-1:0] r_limit;
    logic [sbha_pkg::SLOTS_W-1:0] eff_n;
    logic [WORD_W-1:0]            mask;

    // Control.
    sbha_pkg::t_state r_state, n_state;
    logic             in_go;
    logic             upd_go;

    // Item registers.
    sbha_pkg::t_in_item  r_item;
    sbha_pkg::t_mode     r_mode;
    logic [SLAB_W-1:0]   r_slab;
    logic                r_open_ok;
    logic                r_bad_slab;
    logic [WORD_W-1:0]   r_word;
    logic                r_live;

    // Scan results.
    logic [BYTES-1:0]    r_zb;
    logic [2:0]          r_lz [BYTES];
    logic [BYTES-1:0]    r_one0;
    logic                r_full;
    logic                r_bad;
    logic                r_empty_after;

    logic [BYTES-1:0]    s_zb;
    logic [2:0]          s_lz [BYTES];
    logic [BYTES-1:0]    s_one0;
    logic                s_full;
    logic                s_bad;
    logic                s_empty_after;

    // Update results.
    sbha_pkg::t_slab_wr  wr;
    sbha_pkg::t_stk_op   op;
    sbha_pkg::t_out_item res;
    logic [BYTE_W-1:0]   bj;
    logic [SLOT_W-1:0]   alloc_i;
    logic                single_zero;
    logic [SLOT_W-1:0]   slot;

    // Output register.
    sbha_pkg::t_out_item r_out;
    logic                r_out_valid;

    // Cell chains.
    sbha_pkg::t_open_link open_link [SLABS+1];
    logic [WORD_W-1:0]    slab_word [SLABS];
    logic                 slab_live [SLABS];
    sbha_pkg::t_stk_link  stk_cell  [SLABS];
    logic [SLAB_W-1:0]    stk_top   [SLABS];
    logic                 stk_hit   [SLABS];

    // Configuration writes; a write to an index beyond the list is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= sbha_pkg::SLOTS_W'(sbha_pkg::HANDLES);
            r_limit <= sbha_pkg::LIMIT_W'(SLABS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sbha_pkg::CFG_SLOTS_PER_SLAB: r_slots <= i_cfg_data;
                sbha_pkg::CFG_SLAB_LIMIT:     r_limit <= i_cfg_data[sbha_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Slot count in effect and the mask of the slots in use.
    always_comb begin
        if (r_slots == '0) begin
            eff_n = sbha_pkg::SLOTS_W'(1);
        end else if (r_slots > sbha_pkg::SLOTS_W'(sbha_pkg::HANDLES)) begin
            eff_n = sbha_pkg::SLOTS_W'(sbha_pkg::HANDLES);
        end else begin
            eff_n = r_slots;
        end
        if (eff_n >= sbha_pkg::SLOTS_W'(WORD_W)) begin
            mask = '1;
        end else begin
            mask = (WORD_W'(1) << eff_n) - WORD_W'(1);
        end
    end

    // Slab cells, chained for the search of the lowest unused slab.
    assign open_link[0] = '0;

    for (genvar k = 0; k < SLABS; k++) begin : g_slab
        sbha_slab_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (SLAB_W'(k)),
            .i_limit (r_limit),
            .i_wr    (wr),
            .i_link  (open_link[k]),
            .o_link  (open_link[k+1]),
            .o_word  (slab_word[k]),
            .o_live  (slab_live[k])
        );
    end

    // Stack cells: cell 0 is the bottom, the highest valid cell is the top.
    for (genvar k = 0; k < SLABS; k++) begin : g_stk
        sbha_pkg::t_stk_link above;
        logic [SLAB_W-1:0]   top_in;
        logic                below_valid;
        logic                hit_in;

        if (k == SLABS - 1) begin : g_last
            assign above  = '0;
            assign top_in = '0;
        end else begin : g_mid
            assign above  = stk_cell[k+1];
            assign top_in = stk_top[k+1];
        end

        if (k == 0) begin : g_first
            assign below_valid = 1'b1;
            assign hit_in      = 1'b0;
        end else begin : g_up
            assign below_valid = stk_cell[k-1].valid;
            assign hit_in      = stk_hit[k-1];
        end

        sbha_stack_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (op),
            .i_slab        (r_slab),
            .i_above       (above),
            .i_top_in      (top_in),
            .i_below_valid (below_valid),
            .i_hit_in      (hit_in),
            .o_cell        (stk_cell[k]),
            .o_top_out     (stk_top[k]),
            .o_hit_out     (stk_hit[k])
        );
    end

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbha_pkg::S_IDLE:   if (in_go) n_state = sbha_pkg::S_READ;
            sbha_pkg::S_READ:   n_state = sbha_pkg::S_SCAN;
            sbha_pkg::S_SCAN:   n_state = sbha_pkg::S_UPDATE;
            sbha_pkg::S_UPDATE: if (upd_go) n_state = sbha_pkg::S_IDLE;
            default:            n_state = sbha_pkg::S_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        o_in_ready = 1'b0;
        upd_go     = 1'b0;
        case (r_state)
            sbha_pkg::S_IDLE:   o_in_ready = 1'b1;
            sbha_pkg::S_UPDATE: upd_go = !r_out_valid || i_out_ready;
            default: begin
            end
        endcase
    end

    assign in_go = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Acceptance: pick the slab the item works on.
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_item     <= i_in_data;
            r_open_ok  <= 1'b0;
            r_bad_slab <= 1'b0;
            if (i_in_data.command == sbha_pkg::CMD_FREE) begin
                r_mode     <= sbha_pkg::M_FREE;
                r_slab     <= i_in_data.handle_to_free[SLOT_W +: SLAB_W];
                r_bad_slab <= {1'b0, i_in_data.handle_to_free[sbha_pkg::HANDLE_W-1:SLOT_W]}
                              >= 4'(SLABS);
            end else if (stk_cell[0].valid) begin
                r_mode <= sbha_pkg::M_TOP;
                r_slab <= stk_top[0];
            end else begin
                r_mode    <= sbha_pkg::M_OPEN;
                r_slab    <= open_link[SLABS].idx;
                r_open_ok <= open_link[SLABS].found;
            end
        end
    end

    // Bitmap read from the selected slab cell.
    always_ff @(posedge i_clk) begin
        r_word <= slab_word[r_slab];
        r_live <= slab_live[r_slab];
    end

    assign slot = r_item.handle_to_free[SLOT_W-1:0];

    // Byte-wise scan of the bitmap with the unused slots counted as taken.
    always_comb begin
        logic [WORD_W-1:0] padded;
        logic [7:0]        byt;
        padded = r_word | ~mask;
        for (int j = 0; j < BYTES; j++) begin
            byt       = padded[8*j +: 8];
            s_zb[j]   = ~&byt;
            s_one0[j] = $onehot(~byt);
            s_lz[j]   = 3'd0;
            for (int b = 7; b >= 0; b--) begin
                if (!byt[b]) s_lz[j] = 3'(b);
            end
        end
        s_full        = &padded;
        s_bad         = r_bad_slab || ({1'b0, slot} >= eff_n) || !r_live || !r_word[slot];
        s_empty_after = ~|(r_word & mask & ~(WORD_W'(1) << slot));
    end

    always_ff @(posedge i_clk) begin
        r_zb          <= s_zb;
        r_lz          <= s_lz;
        r_one0        <= s_one0;
        r_full        <= s_full;
        r_bad         <= s_bad;
        r_empty_after <= s_empty_after;
    end

    // Lowest free slot from the scanned bytes.
    always_comb begin
        bj = '0;
        for (int j = BYTES - 1; j >= 0; j--) begin
            if (r_zb[j]) bj = BYTE_W'(j);
        end
        alloc_i     = {bj, r_lz[bj]};
        single_zero = $onehot(r_zb) && r_one0[bj];
    end

    // Update of the cells and the result item.
    always_comb begin
        wr      = '0;
        wr.slab = r_slab;
        op      = '0;
        res     = '0;
        case (r_mode)
            sbha_pkg::M_TOP: begin
                if (r_full) begin
                    // Head slab is full under the current size: drop it and fail.
                    op.pop     = 1'b1;
                    res.status = sbha_pkg::STAT_NOSPACE;
                end else begin
                    wr.en            = 1'b1;
                    wr.word          = r_word | (WORD_W'(1) << alloc_i);
                    wr.live          = 1'b1;
                    op.pop           = single_zero;
                    res.handle_given = {r_slab, alloc_i};
                end
            end
            sbha_pkg::M_OPEN: begin
                if (!r_open_ok) begin
                    res.status = sbha_pkg::STAT_NOSPACE;
                end else begin
                    wr.en            = 1'b1;
                    wr.word          = WORD_W'(1);
                    wr.live          = 1'b1;
                    op.push          = eff_n > sbha_pkg::SLOTS_W'(1);
                    res.handle_given = {r_slab, {SLOT_W{1'b0}}};
                    res.slab_opened  = 1'b1;
                end
            end
            sbha_pkg::M_FREE: begin
                if (r_bad) begin
                    res.status = sbha_pkg::STAT_BADFREE;
                end else if (r_empty_after) begin
                    // Last handle gone: release the slab and take it off the stack.
                    wr.en             = 1'b1;
                    wr.word           = '0;
                    wr.live           = 1'b0;
                    op.remove         = 1'b1;
                    res.slab_released = 1'b1;
                end else begin
                    wr.en   = 1'b1;
                    wr.word = r_word & ~(WORD_W'(1) << slot);
                    wr.live = 1'b1;
                    op.push = r_full && !stk_hit[SLABS-1] && !stk_cell[SLABS-1].valid;
                end
            end
            default: begin
            end
        endcase
        if (!upd_go) begin
            wr.en     = 1'b0;
            op.push   = 1'b0;
            op.pop    = 1'b0;
            op.remove = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/sbha_checker.sv @@
`include "slab_bitmap_handle_allocator_macros.svh"

module sbha_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  sbha_pkg::t_out_item               o_out_data
);

    logic fail_out;
    logic both_flags;
    logic in_acc;

    assign in_acc     = i_in_valid && o_in_ready;
    assign fail_out   = o_out_valid && (o_out_data.status != sbha_pkg::STAT_OK);
    assign both_flags = o_out_data.slab_released && o_out_data.slab_opened;

    // A stalled result item holds.
    `SBHA_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result item changed while stalled")

    // A failed command gives out no handle and changes no slab.
    `SBHA_ASSERT(a_fail_clean, fail_out |-> (o_out_data.handle_given == '0) && !o_out_data.slab_released && !o_out_data.slab_opened, "failed command reports a handle or slab change")

    // A slab is never opened and released by the same command.
    `SBHA_ASSERT(a_one_flag, o_out_valid |-> !both_flags, "opened and released flagged together")

    // After an item is taken the block is busy for the next cycle.
    `SBHA_ASSERT(a_busy, in_acc |=> !o_in_ready, "item taken while still working on the previous one")

    // Leaving reset the block is ready with no result pending.
    `SBHA_ASSERT(a_reset_idle, $past(!i_rst_n) |-> o_in_ready && !o_out_valid, "block not idle after reset")

endmodule

bind slab_bitmap_handle_allocator sbha_checker u_sbha_checker (.*);

@@ tb/handle_result_checker.sv @@
module handle_result_checker
    import sbha_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    // Predicted pool state and register copies.
    logic [WORD_W-1:0]  slab_bits [SLABS];
    logic [SLABS-1:0]   slab_open;
    logic [SLAB_W-1:0]  nonfull_order [SLABS];
    int                 nonfull_depth;
    logic [SLOTS_W-1:0] slots_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Results still owed by the block, oldest first.
    t_out_item results_due [$];
    t_out_item predicted;
    t_out_item want;
    int        mismatches = 0;

    // Slots in use per slab, with zero read as one and large values capped.
    function automatic int slots_in_use();
        int n;
        n = slots_reg;
        if (n < 1) n = 1;
        if (n > HANDLES) n = HANDLES;
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] use_mask();
        int n;
        n = slots_in_use();
        return (n >= WORD_W) ? {WORD_W{1'b1}} : ((WORD_W'(1) << n) - WORD_W'(1));
    endfunction

    // A slab is full when every slot under the current size is taken.
    function automatic bit slab_full(int s);
        return (slab_bits[s] & use_mask()) == use_mask();
    endfunction

    function automatic int order_pos(int s);
        for (int i = 0; i < nonfull_depth; i++)
            if (nonfull_order[i] == s) return i;
        return -1;
    endfunction

    // Push a slab on top of the non-full list unless it is there already.
    task automatic push_nonfull(int s);
        if (nonfull_depth < SLABS && order_pos(s) < 0) begin
            nonfull_order[nonfull_depth] = SLAB_W'(s);
            nonfull_depth++;
        end
    endtask

    // Apply one command to the predicted pool and work out its result.
    task automatic allocate_or_free(input t_in_item item, output t_out_item res);
        int n;
        int s;
        int slot;
        int lim;
        int p;
        bit was_full;
        res = '0;
        n = slots_in_use();
        if (item.command == CMD_FREE) begin
            s    = item.handle_to_free[HANDLE_W-1:SLOT_W];
            slot = item.handle_to_free[SLOT_W-1:0];
            if (slot >= n || !slab_open[s] || !slab_bits[s][slot]) begin
                res.status = STAT_BADFREE;
            end else begin
                was_full = slab_full(s);
                slab_bits[s][slot] = 1'b0;
                if (was_full) push_nonfull(s);
                // An emptied slab is released and drops out of the list in place.
                if ((slab_bits[s] & use_mask()) == '0) begin
                    p = order_pos(s);
                    if (p >= 0) begin
                        for (int i = p; i + 1 < nonfull_depth; i++)
                            nonfull_order[i] = nonfull_order[i + 1];
                        nonfull_depth--;
                    end
                    slab_bits[s]      = '0;
                    slab_open[s]      = 1'b0;
                    res.slab_released = 1'b1;
                end
            end
        end else if (nonfull_depth > 0) begin
            // Take the lowest free slot of the slab on top of the list.
            s    = nonfull_order[nonfull_depth - 1];
            slot = n;
            for (int i = n - 1; i >= 0; i--)
                if (!slab_bits[s][i]) slot = i;
            if (slot >= n) begin
                // The top slab became full through a smaller size.
                nonfull_depth--;
                res.status = STAT_NOSPACE;
            end else begin
                slab_bits[s][slot] = 1'b1;
                if (slab_full(s)) nonfull_depth--;
                res.handle_given = {SLAB_W'(s), SLOT_W'(slot)};
            end
        end else begin
            // Open the lowest unused slab slot under the limit.
            lim = (limit_reg < SLABS) ? int'(limit_reg) : SLABS;
            s   = lim;
            for (int i = lim - 1; i >= 0; i--)
                if (!slab_open[i]) s = i;
            if (s >= lim) begin
                res.status = STAT_NOSPACE;
            end else begin
                slab_open[s] = 1'b1;
                slab_bits[s] = WORD_W'(1);
                if (!slab_full(s)) push_nonfull(s);
                res.handle_given = {SLAB_W'(s), SLOT_W'(0)};
                res.slab_opened  = 1'b1;
            end
        end
    endtask

    // Follow the three channels and compare each result item with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLABS; i++) begin
                slab_bits[i]     = '0;
                nonfull_order[i] = '0;
            end
            slab_open     = '0;
            nonfull_depth = 0;
            slots_reg     = SLOTS_W'(HANDLES);
            limit_reg     = LIMIT_W'(SLABS);
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_SLOTS_PER_SLAB)
                    slots_reg = i_cfg_data[SLOTS_W-1:0];
                else if (i_cfg_index == CFG_SLAB_LIMIT)
                    limit_reg = i_cfg_data[LIMIT_W-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                allocate_or_free(i_in_data, predicted);
                results_due.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result item with none expected: status %0d handle %0d",
                             $time, i_out_data.status, i_out_data.handle_given);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (i_out_data.status !== want.status ||
                        i_out_data.handle_given !== want.handle_given ||
                        i_out_data.slab_released !== want.slab_released ||
                        i_out_data.slab_opened !== want.slab_opened) begin
                        $display("%0t: expected status %0d handle %0d released %0b opened %0b,",
                                 $time, want.status, want.handle_given, want.slab_released,
                                 want.slab_opened,
                                 " actual status %0d handle %0d released %0b opened %0b",
                                 i_out_data.status, i_out_data.handle_given,
                                 i_out_data.slab_released, i_out_data.slab_opened);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= results_due.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    import sbha_pkg::*;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_SLOTS_PER_SLAB;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int results_pending;
    int fail_count;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int slot_span     = HANDLES;
    int slab_span     = SLABS;

    slab_bitmap_handle_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    handle_result_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (results_pending),
        .o_fail_count(fail_count)
    );

    // Clock with a period of four units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("slab_bitmap_handle_allocator: mismatch");
        $finish;
    end

    // Offer one item after a random idle stretch and wait for its acceptance.
    task automatic send_item(input logic cmd, input logic [HANDLE_W-1:0] handle);
        t_in_item item;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        item.command        = cmd;
        item.handle_to_free = handle;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Hold the sender back until every owed result has come out.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle.
    task automatic set_config(input int slots, input int limit);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SLOTS_PER_SLAB;
        i_cfg_data  <= CFG_DATA_W'(slots);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_SLAB_LIMIT;
        i_cfg_data  <= CFG_DATA_W'(limit);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        slot_span = (slots < 1) ? 1 : (slots > HANDLES) ? HANDLES : slots;
        slab_span = (limit < 1 || limit > SLABS) ? SLABS : limit;
    endtask

    initial begin
        int slot_choice [8];
        int limit_choice [8];
        int alloc_pct;
        int pick;
        logic [SLAB_W-1:0] slab;
        logic [SLOT_W-1:0] slot;

        slot_choice  = '{3, 1, 8, 0, 64, 5, 127, 2};
        limit_choice = '{2, 8, 3, 15, 8, 1, 4, 9};
        slot_choice[7] = $urandom_range(2, 12);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two slots per slab, two slabs: fill both, hit the limit, then free back.
        set_config(2, 2);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '1);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_FREE, 9'd1);
        send_item(CMD_FREE, 9'd0);
        send_item(CMD_FREE, 9'd0);
        send_item(CMD_FREE, '1);
        send_item(CMD_FREE, 9'd69);
        send_item(CMD_FREE, 9'd65);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_FREE, 9'd64);
        send_item(CMD_FREE, 9'd65);

        // Shrink the slab size under a partly used top slab.
        set_config(64, 1);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '0);
        set_config(1, 1);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_FREE, 9'd2);
        send_item(CMD_FREE, 9'd0);

        // A zero limit opens nothing; oversized fields fall back to their caps.
        set_config(0, 0);
        send_item(CMD_ALLOC, '1);
        send_item(CMD_FREE, 9'd0);
        set_config(127, 15);
        send_item(CMD_ALLOC, '0);

        // Random phases, each with its own configuration and mix; the idling pattern repeats every four phases.
        for (int phase = 0; phase < 8; phase++) begin
            set_config(slot_choice[phase], limit_choice[phase]);
            case (phase % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 69; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 69; end
                default: begin in_idle_pct = 38; out_stall_pct = 38; end
            endcase
            alloc_pct = $urandom_range(35, 70);
            repeat (78) begin
                pick = $urandom_range(0, 99);
                if (pick < alloc_pct) begin
                    send_item(CMD_ALLOC, HANDLE_W'($urandom));
                end else if (pick < 92) begin
                    // Mostly frees of handles that may well be live.
                    slab = SLAB_W'($urandom_range(0, slab_span - 1));
                    if ($urandom_range(0, 1) == 0)
                        slot = SLOT_W'($urandom_range(0, (slot_span < 8 ? slot_span : 8) - 1));
                    else
                        slot = SLOT_W'($urandom_range(0, slot_span - 1));
                    send_item(CMD_FREE, {slab, slot});
                end else begin
                    send_item(CMD_FREE, HANDLE_W'($urandom));
                end
            end
        end
        in_idle_pct   = 0;
        out_stall_pct = 0;

        wait_for_results();
        if (fail_count == 0)
            $display("slab_bitmap_handle_allocator: match");
        else
            $display("slab_bitmap_handle_allocator: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sbha_pkg.sv
rtl/sbha_slab_cell.sv
rtl/sbha_stack_cell.sv
rtl/slab_bitmap_handle_allocator.sv
rtl/sbha_checker.sv
tb/handle_result_checker.sv
tb/testbench.sv
